// File: src/mbe_pkg.sv
package mbe_pkg;

	// Fixed-point format of all coordinates: signed Q5.58 in 64 bits.
	localparam int unsigned QW        = 64;
	localparam int unsigned FRAC_BITS = 58;

	localparam logic [QW-1:0] Q_MIN     = 64'h8000_0000_0000_0000;
	localparam logic [QW-1:0] Q_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [QW-1:0] Q_TWO     = 64'h0800_0000_0000_0000;
	localparam logic [QW-1:0] Q_NEG_TWO = 64'hF800_0000_0000_0000;
	localparam logic [QW:0]   Q_FOUR    = 65'h0_1000_0000_0000_0000;

	// Default frame size.
	localparam int unsigned DEF_FRAME_WIDTH  = 640;
	localparam int unsigned DEF_FRAME_HEIGHT = 400;

	localparam int unsigned LIMIT_W = 8;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd255;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_START_RE   = 3'd0,
		REG_START_IM   = 3'd1,
		REG_STEP_RE    = 3'd2,
		REG_STEP_IM    = 3'd3,
		REG_ITER_LIMIT = 3'd4
	} cfg_reg_t;

	// Product scaling selected for the shared multiplier.
	typedef enum logic [1:0] {
		MODE_INT   = 2'd0,  // integer times Q5.58, no shift
		MODE_SQ    = 2'd1,  // Q5.58 times Q5.58
		MODE_CROSS = 2'd2   // Q5.58 times Q5.58, doubled
	} mul_mode_t;

	typedef struct packed {
		logic [QW-1:0]      start_re;
		logic [QW-1:0]      start_im;
		logic [QW-1:0]      step_re;
		logic [QW-1:0]      step_im;
		logic [LIMIT_W-1:0] limit;
	} cfg_t;

	typedef struct packed {
		logic          start;
		logic [QW-1:0] a;
		logic [QW-1:0] b;
		mul_mode_t     mode;
	} mbe_mul_req_t;

	typedef struct packed {
		logic          done;
		logic [QW-1:0] res;
	} mbe_mul_rsp_t;

	// Index width for a pixel coordinate, at least one bit.
	function automatic int unsigned coord_width(input int unsigned n);
		int unsigned w;
		w = $clog2(n);
		return (w < 1) ? 1 : w;
	endfunction

	// Saturating Q5.58 addition.
	function automatic logic [QW-1:0] q_add(input logic [QW-1:0] a, input logic [QW-1:0] b);
		logic [QW-1:0] s;
		s = a + b;
		if ((a[QW-1] == b[QW-1]) && (s[QW-1] != a[QW-1]))
			return a[QW-1] ? Q_MIN : Q_MAX;
		return s;
	endfunction

	// Saturating Q5.58 subtraction.
	function automatic logic [QW-1:0] q_sub(input logic [QW-1:0] a, input logic [QW-1:0] b);
		logic [QW-1:0] s;
		s = a - b;
		if ((a[QW-1] != b[QW-1]) && (s[QW-1] != a[QW-1]))
			return a[QW-1] ? Q_MIN : Q_MAX;
		return s;
	endfunction

	// True when -2 < v < 2.
	function automatic logic below_two(input logic [QW-1:0] v);
		return v[QW-1] ? (v > Q_NEG_TWO) : (v < Q_TWO);
	endfunction

endpackage

// File: src/mbe_mul.sv
module mbe_mul import mbe_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  mbe_mul_req_t req,
	output mbe_mul_rsp_t rsp
);

	localparam int unsigned HW = QW / 2;
	localparam int unsigned PW = 2 * QW;

	logic [QW-1:0] a_q, b_q;
	logic          neg_q;
	mul_mode_t     mode_q;
	logic [2:0]    ph_q;
	logic          busy_q;
	logic          done_q;
	logic [1:0]    pidx_q;
	logic [QW-1:0] prod_q;
	logic [PW-1:0] acc_q;
	logic [QW-1:0] res_q;

	logic [HW-1:0] a_part, b_part;
	logic [PW-1:0] prod_shifted;
	logic [QW-1:0] quot, fmt;
	logic          rnd;

	// One 32x32 partial product per phase, chosen by the phase counter.
	assign a_part = ph_q[1] ? a_q[QW-1:HW] : a_q[HW-1:0];
	assign b_part = ph_q[0] ? b_q[QW-1:HW] : b_q[HW-1:0];

	// Place the previous partial product at its weight.
	always_comb begin
		unique case (pidx_q)
			2'd0:    prod_shifted = {{QW{1'b0}}, prod_q};
			2'd3:    prod_shifted = {prod_q, {QW{1'b0}}};
			default: prod_shifted = {{HW{1'b0}}, prod_q, {HW{1'b0}}};
		endcase
	end

	// Scale and floor the magnitude into a signed Q5.58 result; only integer mode saturates.
	always_comb begin
		quot = acc_q[QW-1:0];
		rnd  = 1'b0;
		fmt  = acc_q[QW-1:0];
		unique case (mode_q)
			MODE_INT: begin
				if (neg_q)
					fmt = (acc_q > {{QW{1'b0}}, Q_MIN}) ? Q_MIN : (~acc_q[QW-1:0] + 1'b1);
				else
					fmt = (acc_q > {{QW{1'b0}}, Q_MAX}) ? Q_MAX : acc_q[QW-1:0];
			end
			MODE_SQ: begin
				quot = acc_q[FRAC_BITS +: QW];
				rnd  = |acc_q[FRAC_BITS-1:0];
				fmt  = neg_q ? (~(quot + {{(QW-1){1'b0}}, rnd}) + 1'b1) : quot;
			end
			MODE_CROSS: begin
				quot = acc_q[FRAC_BITS-1 +: QW];
				rnd  = |acc_q[FRAC_BITS-2:0];
				fmt  = neg_q ? (~(quot + {{(QW-1){1'b0}}, rnd}) + 1'b1) : quot;
			end
			default: fmt = acc_q[QW-1:0];
		endcase
	end

	// Control: phases 0-3 multiply, 1-4 accumulate, 5 formats the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ph_q   <= 3'd0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			ph_q   <= 3'd0;
		end else if (busy_q) begin
			ph_q <= ph_q + 3'd1;
			if (ph_q == 3'd5) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Operand magnitudes, partial products and the accumulator.
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q    <= req.a[QW-1] ? (~req.a + 1'b1) : req.a;
			b_q    <= req.b[QW-1] ? (~req.b + 1'b1) : req.b;
			neg_q  <= req.a[QW-1] ^ req.b[QW-1];
			mode_q <= req.mode;
			acc_q  <= '0;
		end else if (busy_q) begin
			if (ph_q <= 3'd3) begin
				prod_q <= a_part * b_part;
				pidx_q <= ph_q[1:0];
			end
			if ((ph_q >= 3'd1) && (ph_q <= 3'd4))
				acc_q <= acc_q + prod_shifted;
			if (ph_q == 3'd5)
				res_q <= fmt;
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = res_q;

	// A new product is requested only when the unit is free.
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("multiplier started while busy");

	// The completion flag is a single-cycle pulse.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("multiplier done held for more than one cycle");

endmodule

// File: src/mbe_seq.sv
module mbe_seq import mbe_pkg::*; #(
	parameter int unsigned FRAME_WIDTH  = DEF_FRAME_WIDTH,
	parameter int unsigned FRAME_HEIGHT = DEF_FRAME_HEIGHT
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  cfg_t                                  cfg,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [coord_width(FRAME_WIDTH)-1:0]   column,
	input  logic [coord_width(FRAME_HEIGHT)-1:0]  row,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [LIMIT_W-1:0]                    iteration_count,
	output mbe_mul_req_t                          mul_req,
	input  mbe_mul_rsp_t                          mul_rsp
);

	localparam int unsigned COL_W = coord_width(FRAME_WIDTH);
	localparam int unsigned ROW_W = coord_width(FRAME_HEIGHT);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_MUL_RE = 8'b0000_0010,
		S_MUL_IM = 8'b0000_0100,
		S_TEST   = 8'b0000_1000,
		S_SQ_R   = 8'b0001_0000,
		S_SQ_I   = 8'b0010_0000,
		S_CROSS  = 8'b0100_0000,
		S_OUT    = 8'b1000_0000
	} state_t;

	state_t             state_q, state_d;
	logic [ROW_W-1:0]   row_q;
	logic [QW-1:0]      cr_q, ci_q, zr_q, zi_q, sr_q, d_q;
	logic [LIMIT_W-1:0] count_q;

	logic          accept;
	logic          stop_test;
	logic          escaped;
	logic [QW-1:0] ci_new;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign iteration_count = count_q;

	assign stop_test = (count_q >= cfg.limit) || !below_two(zr_q) || !below_two(zi_q);
	assign escaped   = ({1'b0, sr_q} + {1'b0, mul_rsp.res}) >= Q_FOUR;
	assign ci_new    = q_add(cfg.start_im, mul_rsp.res);

	// Next state and multiplier requests.
	always_comb begin
		state_d      = state_q;
		mul_req      = '0;
		mul_req.mode = MODE_SQ;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					mul_req.start = 1'b1;
					mul_req.a     = {{(QW-COL_W){1'b0}}, column};
					mul_req.b     = cfg.step_re;
					mul_req.mode  = MODE_INT;
					state_d       = S_MUL_RE;
				end
			end
			S_MUL_RE: begin
				if (mul_rsp.done) begin
					mul_req.start = 1'b1;
					mul_req.a     = {{(QW-ROW_W){1'b0}}, row_q};
					mul_req.b     = cfg.step_im;
					mul_req.mode  = MODE_INT;
					state_d       = S_MUL_IM;
				end
			end
			S_MUL_IM: begin
				if (mul_rsp.done)
					state_d = S_TEST;
			end
			S_TEST: begin
				if (stop_test) begin
					state_d = S_OUT;
				end else begin
					mul_req.start = 1'b1;
					mul_req.a     = zr_q;
					mul_req.b     = zr_q;
					state_d       = S_SQ_R;
				end
			end
			S_SQ_R: begin
				if (mul_rsp.done) begin
					mul_req.start = 1'b1;
					mul_req.a     = zi_q;
					mul_req.b     = zi_q;
					state_d       = S_SQ_I;
				end
			end
			S_SQ_I: begin
				if (mul_rsp.done) begin
					if (escaped) begin
						state_d = S_OUT;
					end else begin
						mul_req.start = 1'b1;
						mul_req.a     = zi_q;
						mul_req.b     = zr_q;
						mul_req.mode  = MODE_CROSS;
						state_d       = S_CROSS;
					end
				end
			end
			S_CROSS: begin
				if (mul_rsp.done)
					state_d = S_TEST;
			end
			S_OUT: begin
				if (!out_stall)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept)
				count_q <= '0;
			else if ((state_q == S_CROSS) && mul_rsp.done)
				count_q <= count_q + 1'b1;
		end
	end

	// Point and orbit registers.
	always_ff @(posedge clk) begin
		if (accept)
			row_q <= row;
		if ((state_q == S_MUL_RE) && mul_rsp.done)
			cr_q <= q_add(cfg.start_re, mul_rsp.res);
		if ((state_q == S_MUL_IM) && mul_rsp.done) begin
			ci_q <= ci_new;
			zr_q <= cr_q;
			zi_q <= ci_new;
		end
		if ((state_q == S_SQ_R) && mul_rsp.done)
			sr_q <= mul_rsp.res;
		if ((state_q == S_SQ_I) && mul_rsp.done)
			d_q <= q_sub(sr_q, mul_rsp.res);
		if ((state_q == S_CROSS) && mul_rsp.done) begin
			zr_q <= q_add(d_q, cr_q);
			zi_q <= q_add(mul_rsp.res, ci_q);
		end
	end

	// An accepted pixel always starts with the real coordinate product.
	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_MUL_RE))
		else $error("accepted pixel did not start the coordinate product");

	// Products only complete while the sequencer waits for one.
	a_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		mul_rsp.done |-> ((state_q == S_MUL_RE) || (state_q == S_MUL_IM) ||
			(state_q == S_SQ_R) || (state_q == S_SQ_I) || (state_q == S_CROSS)))
		else $error("product completed in an unexpected state");

	// The iteration count never passes the limit.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_TEST) || (state_q == S_OUT)) |-> (count_q <= cfg.limit))
		else $error("iteration count exceeded the limit");

endmodule

// File: src/mandelbrot_escape_time_top.sv
// Mandelbrot escape-time unit.
// Input channel (in_valid / in_stall) carries one pixel as column and row.
// The unit forms c = start_re + column*step_re + i*(start_im + row*step_im)
// in signed Q5.58, iterates z = z*z + c from z = c and returns on the output
// channel (out_valid / out_stall) the number of iterations done before
// |z|^2 reaches 4, the real or imaginary part of z reaches magnitude 2, or
// the count reaches the iteration limit. All products run on one 32x32
// multiplier, four partial products per 64-bit product. One pixel is handled
// at a time: in_stall stays high from acceptance until the result transaction
// completes. The next pixel can be taken in the cycle after that.
// While out_stall is high the result is held and no new pixel is taken.
// Configuration is written via cfg_write / cfg_index / cfg_data. The user must
// write it only while the unit is idle, which it does not enforce. Unknown
// indexes are ignored. Reset clears the start and step registers to zero,
// sets the limit to 255 and returns the unit to idle with no result pending.
module mandelbrot_escape_time_top import mbe_pkg::*; #(
	parameter int unsigned FRAME_WIDTH  = DEF_FRAME_WIDTH,
	parameter int unsigned FRAME_HEIGHT = DEF_FRAME_HEIGHT
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_write,
	input  logic [2:0]                            cfg_index,
	input  logic [QW-1:0]                         cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [coord_width(FRAME_WIDTH)-1:0]   column,
	input  logic [coord_width(FRAME_HEIGHT)-1:0]  row,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [LIMIT_W-1:0]                    iteration_count
);

	cfg_t         cfg_q;
	mbe_mul_req_t mul_req;
	mbe_mul_rsp_t mul_rsp;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_re <= '0;
			cfg_q.start_im <= '0;
			cfg_q.step_re  <= '0;
			cfg_q.step_im  <= '0;
			cfg_q.limit    <= LIMIT_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_START_RE:   cfg_q.start_re <= cfg_data;
				REG_START_IM:   cfg_q.start_im <= cfg_data;
				REG_STEP_RE:    cfg_q.step_re  <= cfg_data;
				REG_STEP_IM:    cfg_q.step_im  <= cfg_data;
				REG_ITER_LIMIT: cfg_q.limit    <= cfg_data[LIMIT_W-1:0];
				default:        cfg_q.limit    <= cfg_q.limit;
			endcase
		end
	end

	mbe_seq #(
		.FRAME_WIDTH  (FRAME_WIDTH),
		.FRAME_HEIGHT (FRAME_HEIGHT)
	) u_seq (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.column          (column),
		.row             (row),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.iteration_count (iteration_count),
		.mul_req         (mul_req),
		.mul_rsp         (mul_rsp)
	);

	mbe_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

endmodule
